/* rtl/rth_pkg.sv */
// Package with the shared constants and stage record of the pixel colour-space converter.
`timescale 1ns / 1ps
`default_nettype none
package rth_pkg;
   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned QUOT_W     = 8;
   localparam int unsigned REM_W      = 17;
   localparam int unsigned HDIV_W     = CHAN_W + 1;
   localparam int unsigned HUE_SECTOR = 60;
   localparam int unsigned HUE_GREEN  = 120;
   localparam int unsigned HUE_BLUE   = 240;
   localparam int unsigned HUE_FULL   = 360;
   localparam int unsigned SAT_SCALE  = 255;

   typedef struct packed {
      logic                valid;
      logic [REM_W-1:0]    rem_sat;
      logic [CHAN_W-1:0]   div_sat;
      logic [QUOT_W-1:0]   quo_sat;
      logic [REM_W-1:0]    rem_hue;
      logic [HDIV_W-1:0]   div_hue;
      logic [QUOT_W-1:0]   quo_hue;
      logic [CHAN_W-1:0]   bright;
   } stage_type;
endpackage
`default_nettype wire

/* rtl/rth_if.sv */
// Interfaces for the pixel request and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface rth_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;
   modport source (output valid, blue, green, red, input ready);
   modport sink (input valid, blue, green, red, output ready);
endinterface

interface rth_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] hue_half;
   logic [7:0] saturation;
   logic [7:0] brightness;
   modport source (output valid, hue_half, saturation, brightness, input ready);
   modport sink (input valid, hue_half, saturation, brightness, output ready);
endinterface
`default_nettype wire

/* rtl/rth_front.sv */
// Front stage: channel extremes and the dividends and divisors for both quotients.
`timescale 1ns / 1ps
`default_nettype none
module rth_front import rth_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire logic [CHAN_W-1:0] blue,
   input  wire logic [CHAN_W-1:0] green,
   input  wire logic [CHAN_W-1:0] red,
   output stage_type              out_ff
);
   logic [CHAN_W-1:0] mx;
   logic [CHAN_W-1:0] mn;
   logic [CHAN_W-1:0] dif;
   logic signed [19:0] diff_s;
   logic signed [19:0] num;
   logic [15:0]        sat_num;
   stage_type          out_in;

   always_comb begin
      mx = blue;
      if (green > mx) mx = green;
      if (red > mx) mx = red;
      mn = blue;
      if (green < mn) mn = green;
      if (red < mn) mn = red;
      dif = mx - mn;
      if (mx == red) begin
         diff_s = $signed({12'd0, green}) - $signed({12'd0, blue});
         num    = diff_s * 20'(HUE_SECTOR);
         if (num < 0) num = num + $signed(20'(HUE_FULL) * {12'd0, dif});
      end else if (mx == green) begin
         diff_s = $signed({12'd0, blue}) - $signed({12'd0, red});
         num    = $signed(20'(HUE_GREEN) * {12'd0, dif}) + diff_s * 20'(HUE_SECTOR);
      end else begin
         diff_s = $signed({12'd0, red}) - $signed({12'd0, green});
         num    = $signed(20'(HUE_BLUE) * {12'd0, dif}) + diff_s * 20'(HUE_SECTOR);
      end
      if (num < 0 || dif == '0) num = '0;
      sat_num = 16'(16'({8'd0, dif}) * 16'(SAT_SCALE));

      out_in.valid   = in_valid;
      out_in.rem_sat = REM_W'(sat_num);
      out_in.div_sat = (mx == '0) ? CHAN_W'(1) : mx;
      out_in.quo_sat = '0;
      out_in.rem_hue = num[REM_W-1:0];
      out_in.div_hue = (dif == '0) ? HDIV_W'(1) : {dif, 1'b0};
      out_in.quo_hue = '0;
      out_in.bright  = mx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         out_ff.valid <= out_in.valid;
      end
      if (advance) begin
         out_ff.rem_sat <= out_in.rem_sat;
         out_ff.div_sat <= out_in.div_sat;
         out_ff.quo_sat <= out_in.quo_sat;
         out_ff.rem_hue <= out_in.rem_hue;
         out_ff.div_hue <= out_in.div_hue;
         out_ff.quo_hue <= out_in.quo_hue;
         out_ff.bright  <= out_in.bright;
      end
   end
endmodule
`default_nettype wire

/* rtl/rth_cell.sv */
// Division cell: settles one quotient bit of both the saturation and the hue quotient.
`timescale 1ns / 1ps
`default_nettype none
module rth_cell import rth_pkg::*; #(
   parameter int unsigned BIT = 0
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic advance,
   input  stage_type in_st,
   output stage_type out_ff
);
   logic [REM_W:0] sub_sat;
   logic [REM_W:0] sub_hue;
   stage_type      out_in;

   always_comb begin
      sub_sat = (REM_W+1)'(in_st.div_sat) << BIT;
      sub_hue = (REM_W+1)'(in_st.div_hue) << BIT;
      out_in  = in_st;
      if ({1'b0, in_st.rem_sat} >= sub_sat) begin
         out_in.rem_sat      = in_st.rem_sat - sub_sat[REM_W-1:0];
         out_in.quo_sat[BIT] = 1'b1;
      end
      if ({1'b0, in_st.rem_hue} >= sub_hue) begin
         out_in.rem_hue      = in_st.rem_hue - sub_hue[REM_W-1:0];
         out_in.quo_hue[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         out_ff.valid <= out_in.valid;
      end
      if (advance) begin
         out_ff.rem_sat <= out_in.rem_sat;
         out_ff.div_sat <= out_in.div_sat;
         out_ff.quo_sat <= out_in.quo_sat;
         out_ff.rem_hue <= out_in.rem_hue;
         out_ff.div_hue <= out_in.div_hue;
         out_ff.quo_hue <= out_in.quo_hue;
         out_ff.bright  <= out_in.bright;
      end
   end
endmodule
`default_nettype wire

/* rtl/rgb_to_hsv_pixel.sv */
// Top level of the pixel converter from blue, green and red to hue, saturation and value.
`timescale 1ns / 1ps
`default_nettype none
// One pixel is taken in every cycle while the row advances: a front stage finds the largest
// and smallest channel and forms both dividends, then a row of eight identical cells each
// settles one quotient bit of saturation and of hue, each in its own register. The whole
// row advances together and halts only while a finished result waits to be taken.
module rgb_to_hsv_pixel import rth_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   rth_req_if.sink   req_chan,
   rth_rsp_if.source rsp_chan
);
   stage_type chain [0:QUOT_W];
   logic      advance;

   assign advance        = !chain[QUOT_W].valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   rth_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_chan.valid),
      .blue     (req_chan.blue),
      .green    (req_chan.green),
      .red      (req_chan.red),
      .out_ff   (chain[0])
   );

   for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
      rth_cell #(.BIT(QUOT_W - 1 - i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .in_st   (chain[i]),
         .out_ff  (chain[i+1])
      );
   end

   assign rsp_chan.valid      = chain[QUOT_W].valid;
   assign rsp_chan.hue_half   = chain[QUOT_W].quo_hue;
   assign rsp_chan.saturation = chain[QUOT_W].quo_sat;
   assign rsp_chan.brightness = chain[QUOT_W].bright;
endmodule
`default_nettype wire

/* rtl/rth_checker.sv */
// Port checker for the pixel converter and its binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rth_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] hue_half,
   input wire logic [7:0] saturation,
   input wire logic [7:0] brightness
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(hue_half) && $stable(saturation)
         && $stable(brightness))
      else $error("A stalled result transaction changed.");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("Request ready does not follow the result side.");
   a_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> hue_half < 8'd180)
      else $error("Hue out of range.");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && brightness == 8'd0 |-> saturation == 8'd0 && hue_half == 8'd0)
      else $error("Black pixel gave colour.");
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("Result valid straight after reset.");
endmodule

bind rgb_to_hsv_pixel rth_checker u_rth_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .hue_half   (rsp_chan.hue_half),
   .saturation (rsp_chan.saturation),
   .brightness (rsp_chan.brightness)
);
`default_nettype wire
